>>> hdl/sha1md_pkg.sv
// Shared types, constants and helper functions of the SHA-1 digest unit.
`default_nettype none
package sha1md_pkg;

    // Standard SHA-1 initial chaining values.
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // Round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int WORD_CNT_W  = 4;
    localparam int ROUND_CNT_W = 7;
    localparam int INDEX_W     = 3;

    localparam logic [WORD_CNT_W-1:0] LAST_BLOCK_WORD = 4'd15;
    localparam logic [WORD_CNT_W-1:0] LEN_HI_WORD     = 4'd14;
    localparam logic [WORD_CNT_W-1:0] PRE_LEN_WORD    = 4'd13;

    localparam logic [ROUND_CNT_W-1:0] ROUND_GROUP1 = 7'd20;
    localparam logic [ROUND_CNT_W-1:0] ROUND_GROUP2 = 7'd40;
    localparam logic [ROUND_CNT_W-1:0] ROUND_GROUP3 = 7'd60;
    localparam logic [ROUND_CNT_W-1:0] ROUND_LAST   = 7'd79;

    localparam logic [INDEX_W-1:0] DIGEST_LAST_IDX = 3'd4;
    localparam int DIGEST_WORDS = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT = 3'd4;

    // One 32-bit message word on its way to the compression core.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } word_item_t;

    typedef enum logic [2:0] {
        FR_BYTES,
        FR_PAD,
        FR_ZERO,
        FR_LEN_HI,
        FR_LEN_LO
    } fr_state_t;

    typedef enum logic [1:0] {
        CO_LOAD,
        CO_ROUND,
        CO_ADD,
        CO_EMIT
    } co_state_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha1md_front.sv
// Front end: packs message bytes into words, counts bits and generates padding.
`default_nettype none
module sha1md_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  byte_valid,
    input  wire logic                  end_of_message,
    output logic                       push,
    output sha1md_pkg::word_item_t     push_item,
    input  wire logic                  queue_full
);

    sha1md_pkg::fr_state_t state_reg, state_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  byte_cnt_reg, byte_cnt_next;
    logic [sha1md_pkg::WORD_CNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic [63:0] bit_cnt_reg, bit_cnt_next;
    logic        in_fire;
    logic [31:0] pad_word;

    assign in_stall = (state_reg != sha1md_pkg::FR_BYTES) || queue_full;
    assign in_fire  = in_valid && !in_stall;

    // The partial word followed by the 0x80 marker and any zero fill.
    always_comb
    begin
        case (byte_cnt_reg)
            2'd0:    pad_word = {sha1md_pkg::PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg, sha1md_pkg::PAD_BYTE};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1md_pkg::FR_BYTES:
                if (in_fire && end_of_message)
                    state_next = sha1md_pkg::FR_PAD;
            sha1md_pkg::FR_PAD:
                if (!queue_full)
                    state_next = (word_cnt_reg == sha1md_pkg::PRE_LEN_WORD) ?
                                 sha1md_pkg::FR_LEN_HI : sha1md_pkg::FR_ZERO;
            sha1md_pkg::FR_ZERO:
                if (!queue_full && word_cnt_reg == sha1md_pkg::PRE_LEN_WORD)
                    state_next = sha1md_pkg::FR_LEN_HI;
            sha1md_pkg::FR_LEN_HI:
                if (!queue_full)
                    state_next = sha1md_pkg::FR_LEN_LO;
            sha1md_pkg::FR_LEN_LO:
                if (!queue_full)
                    state_next = sha1md_pkg::FR_BYTES;
            default:
                state_next = sha1md_pkg::FR_BYTES;
        endcase
    end

    always_comb
    begin
        push           = 1'b0;
        push_item.word = {acc_reg, data_byte};
        push_item.last = 1'b0;
        unique case (state_reg)
            sha1md_pkg::FR_BYTES:
                push = in_fire && byte_valid && (byte_cnt_reg == 2'd3);
            sha1md_pkg::FR_PAD:
            begin
                push           = !queue_full;
                push_item.word = pad_word;
            end
            sha1md_pkg::FR_ZERO:
            begin
                push           = !queue_full;
                push_item.word = 32'h0;
            end
            sha1md_pkg::FR_LEN_HI:
            begin
                push           = !queue_full;
                push_item.word = bit_cnt_reg[63:32];
            end
            sha1md_pkg::FR_LEN_LO:
            begin
                push           = !queue_full;
                push_item.word = bit_cnt_reg[31:0];
                push_item.last = 1'b1;
            end
            default:
                push = 1'b0;
        endcase
    end

    always_comb
    begin
        acc_next      = acc_reg;
        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        word_cnt_next = word_cnt_reg + {{(sha1md_pkg::WORD_CNT_W-1){1'b0}}, push};
        if (in_fire && byte_valid)
        begin
            bit_cnt_next  = bit_cnt_reg + 64'd8;
            acc_next      = {acc_reg[15:0], data_byte};
            byte_cnt_next = byte_cnt_reg + 2'd1;
        end
        if (state_reg == sha1md_pkg::FR_PAD && !queue_full)
            byte_cnt_next = 2'd0;
        // The message is closed once the low length word is queued.
        if (state_reg == sha1md_pkg::FR_LEN_LO && !queue_full)
            bit_cnt_next = 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1md_pkg::FR_BYTES;
            byte_cnt_reg <= 2'd0;
            word_cnt_reg <= '0;
            bit_cnt_reg  <= 64'd0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            word_cnt_reg <= word_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule
`default_nettype wire

>>> hdl/sha1md_queue.sv
// Short word queue between the front end and the compression core.
`default_nettype none
module sha1md_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  sha1md_pkg::word_item_t      push_item,
    output logic                        full,
    input  wire logic                   pop,
    output sha1md_pkg::word_item_t      pop_item,
    output logic                        empty
);

    sha1md_pkg::word_item_t entry_reg [sha1md_pkg::QUEUE_DEPTH];
    logic [sha1md_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sha1md_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == sha1md_pkg::QUEUE_FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + {{(sha1md_pkg::QUEUE_CNT_W-1){1'b0}}, 1'b1};
        else if (do_pop && !do_push)
            count_next = count_reg - {{(sha1md_pkg::QUEUE_CNT_W-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + {{(sha1md_pkg::QUEUE_PTR_W-1){1'b0}}, 1'b1};
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + {{(sha1md_pkg::QUEUE_PTR_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

>>> hdl/sha1md_core.sv
// Compression core: loads 16 words, runs 80 rounds, updates the chain, emits the digest.
`default_nettype none
module sha1md_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    output logic                        pop,
    input  sha1md_pkg::word_item_t      pop_item,
    input  wire logic                   empty,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 digest_word,
    output logic [sha1md_pkg::INDEX_W-1:0] word_index,
    output logic                        last_word
);

    sha1md_pkg::co_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] chain_reg [sha1md_pkg::DIGEST_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [sha1md_pkg::WORD_CNT_W-1:0]  load_cnt_reg;
    logic [sha1md_pkg::ROUND_CNT_W-1:0] round_cnt_reg;
    logic [sha1md_pkg::INDEX_W-1:0]     idx_reg;
    logic        last_reg;
    logic        out_fire, load_done, shift_en;
    logic [31:0] f_val, k_val, sum_val, w_new, shift_in;

    assign out_fire  = out_valid && !out_stall;
    assign load_done = pop && (load_cnt_reg == sha1md_pkg::LAST_BLOCK_WORD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1md_pkg::CO_LOAD:
                if (load_done)
                    state_next = sha1md_pkg::CO_ROUND;
            sha1md_pkg::CO_ROUND:
                if (round_cnt_reg == sha1md_pkg::ROUND_LAST)
                    state_next = sha1md_pkg::CO_ADD;
            sha1md_pkg::CO_ADD:
                state_next = last_reg ? sha1md_pkg::CO_EMIT : sha1md_pkg::CO_LOAD;
            sha1md_pkg::CO_EMIT:
                if (out_fire && idx_reg == sha1md_pkg::DIGEST_LAST_IDX)
                    state_next = sha1md_pkg::CO_LOAD;
            default:
                state_next = sha1md_pkg::CO_LOAD;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        out_valid = 1'b0;
        shift_en  = 1'b0;
        shift_in  = pop_item.word;
        unique case (state_reg)
            sha1md_pkg::CO_LOAD:
            begin
                pop      = !empty;
                shift_en = !empty;
            end
            sha1md_pkg::CO_ROUND:
            begin
                shift_en = 1'b1;
                shift_in = w_new;
            end
            sha1md_pkg::CO_ADD:
                pop = 1'b0;
            sha1md_pkg::CO_EMIT:
                out_valid = 1'b1;
            default:
                pop = 1'b0;
        endcase
    end

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha1md_pkg::DIGEST_LAST_IDX);

    // The window holds W[t] .. W[t+15]; W[t] is at the bottom.
    assign w_new = sha1md_pkg::rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);

    always_comb
    begin
        if (round_cnt_reg < sha1md_pkg::ROUND_GROUP1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K0;
        end
        else if (round_cnt_reg < sha1md_pkg::ROUND_GROUP2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K1;
        end
        else if (round_cnt_reg < sha1md_pkg::ROUND_GROUP3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K3;
        end
        sum_val = sha1md_pkg::rotl5(a_reg) + f_val + e_reg + k_val + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1md_pkg::CO_LOAD;
            load_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            chain_reg[0]  <= sha1md_pkg::H0;
            chain_reg[1]  <= sha1md_pkg::H1;
            chain_reg[2]  <= sha1md_pkg::H2;
            chain_reg[3]  <= sha1md_pkg::H3;
            chain_reg[4]  <= sha1md_pkg::H4;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                load_cnt_reg <= load_cnt_reg + {{(sha1md_pkg::WORD_CNT_W-1){1'b0}}, 1'b1};
            if (load_done)
                last_reg <= pop_item.last;
            if (state_reg == sha1md_pkg::CO_ROUND)
            begin
                if (round_cnt_reg == sha1md_pkg::ROUND_LAST)
                    round_cnt_reg <= '0;
                else
                    round_cnt_reg <= round_cnt_reg +
                                     {{(sha1md_pkg::ROUND_CNT_W-1){1'b0}}, 1'b1};
            end
            if (state_reg == sha1md_pkg::CO_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (out_fire)
            begin
                if (idx_reg == sha1md_pkg::DIGEST_LAST_IDX)
                begin
                    // Digest delivered: start the next message from the initial values.
                    idx_reg      <= '0;
                    chain_reg[0] <= sha1md_pkg::H0;
                    chain_reg[1] <= sha1md_pkg::H1;
                    chain_reg[2] <= sha1md_pkg::H2;
                    chain_reg[3] <= sha1md_pkg::H3;
                    chain_reg[4] <= sha1md_pkg::H4;
                end
                else
                    idx_reg <= idx_reg + {{(sha1md_pkg::INDEX_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= shift_in;
        end
        if (load_done)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (state_reg == sha1md_pkg::CO_ROUND)
        begin
            a_reg <= sum_val;
            b_reg <= a_reg;
            c_reg <= sha1md_pkg::rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::CO_ROUND) |-> (round_cnt_reg <= sha1md_pkg::ROUND_LAST))
        else $error("round counter ran past the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::CO_ROUND) |-> (load_cnt_reg == '0))
        else $error("rounds started without a whole block loaded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::CO_ADD && !last_reg) |=> (state_reg == sha1md_pkg::CO_LOAD))
        else $error("digest emitted for a block that does not end a message");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && idx_reg == sha1md_pkg::DIGEST_LAST_IDX)
        |=> (state_reg == sha1md_pkg::CO_LOAD && chain_reg[0] == sha1md_pkg::H0
             && idx_reg == '0))
        else $error("chain not reinitialized after the final digest word");
`endif

endmodule
`default_nettype wire

>>> hdl/sha1_message_digest_unit.sv
// Top level of the SHA-1 message digest unit.
// Usage: the input channel (in_valid/in_stall) takes one item per cycle unless stalled:
// a message byte in data_byte, qualified by byte_valid, and end_of_message to close the
// message after that byte. An item with end_of_message and no valid byte closes the
// message without adding data, so the empty message is supported.
// Bytes are packed into words and pass through a four-word queue to the compression
// core. A block needs 16 word loads, 80 rounds at one round per cycle and one chaining
// update. The queue holds only 16 bytes of the next block, so input stalls while the
// core runs the rounds and chaining update of a block. Input is stalled while the queue
// is full. On end of message the front end queues 3 to 18 padding and length words and
// stalls input meanwhile; the first digest word can be taken once the final block has
// passed its rounds and chaining update, later when an extra padding block or a block
// still in the round loop comes first. The digest leaves on the output channel
// (out_valid/out_stall) as five items, word_index 0 to 4, last_word set on the fifth.
// While the receiver stalls, the current digest word holds and the front end keeps
// filling the queue. After the fifth word is taken the chain returns to the SHA-1
// initial values. Reset (rst_n low) clears all control state and loads the initial
// chain values; the block is ready as soon as reset is released.
`default_nettype none
module sha1_message_digest_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha1md_pkg::word_item_t push_item, pop_item;
    logic push, pop, queue_full, queue_empty;

    sha1md_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    sha1md_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    sha1md_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (pop),
        .pop_item    (pop_item),
        .empty       (queue_empty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
`default_nettype wire
